/* rtl/core/assert_macros.svh */
// Assertion macros shared by the envelope generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define EG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every rising clock edge out of reset.
`define EG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EG_ASSERT_IMPLY(label, ante, cons, msg)
`define EG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/eg_pkg.sv */
// Types, constants and the increment function of the envelope generator.
package eg_pkg;

    localparam int NUM_VOICES = 32;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam int CMD_W   = 2;
    localparam int VOICE_W = 5;
    localparam int RATE_W  = 6;
    localparam int DL_W    = 5;
    localparam int CYCLE_W = 12;
    localparam int LEVEL_W = 10;
    localparam int INC_W   = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 10'h3FF;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP    = 2'd0,
        CMD_KEY_ON  = 2'd1,
        CMD_KEY_OFF = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY1  = 2'd1,
        PH_DECAY2  = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        OP_STEP,
        OP_KEY_ON,
        OP_KEY_OFF,
        OP_NOP,
        OP_BAD_VOICE
    } op_kind_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        op_kind_t            kind;
        logic [VIDX_W-1:0]   vidx;
        logic [INC_W-1:0]    inc;
        logic [DL_W-1:0]     decay_level;
        logic                hold_attack;
    } op_t;

    // Low-rate patterns, bit i is the increment (0 or 1) at cycle select i.
    localparam logic [7:0] LOW_PATTERN [4] = '{
        8'b10101010,
        8'b10111010,
        8'b11101110,
        8'b11111110
    };

    // High-rate patterns, bit i set means an increment of 2 instead of 1.
    localparam logic [7:0] HIGH_PATTERN [4] = '{
        8'b00000000,
        8'b10001000,
        8'b10101010,
        8'b11101110
    };

    // Level increment for one envelope step at the given rate and cycle.
    function automatic logic [INC_W-1:0] env_increment(
        input logic [RATE_W-1:0]  rate,
        input logic [CYCLE_W-1:0] cycle
    );
        logic [3:0]         shift;
        logic [CYCLE_W-1:0] mask;
        logic [2:0]         sel;
        logic [1:0]         scale;
        logic [INC_W-1:0]   base;
        logic [INC_W-1:0]   result;
        shift = (rate < 6'd44) ? 4'(4'd11 - 4'(rate[5:2])) : 4'd0;
        mask  = (CYCLE_W'(1) << shift) - CYCLE_W'(1);
        sel   = 3'(cycle >> shift);
        scale = 2'(rate[5:2] - 4'd12);
        base  = HIGH_PATTERN[rate[1:0]][sel] ? 4'd2 : 4'd1;
        if ((cycle & mask) != '0)
            result = '0;
        else if (rate < 6'd2)
            result = '0;
        else if (rate < 6'd48)
            result = {3'b000, LOW_PATTERN[rate[1:0]][sel]};
        else if (rate < 6'd60)
            result = base << scale;
        else
            result = 4'd8;
        return result;
    endfunction

endpackage

/* rtl/core/eg_front.sv */
// Front end: takes input items, works out the increment and classifies the command.
module eg_front
    import eg_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: voice[4:0], rate[10:5], decay_level[15:11], hold_attack[16],
    //        eg_cycle[28:17], zero fill[31:29]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [CMD_W-1:0]     s_axis_tuser,
    input  logic                 q_full,
    output logic                 push,
    output op_t                  push_data
);

    logic [VOICE_W-1:0] voice;
    logic [RATE_W-1:0]  rate;
    logic [CYCLE_W-1:0] eg_cycle;
    cmd_t               cmd;

    assign voice    = s_axis_tdata[4:0];
    assign rate     = s_axis_tdata[10:5];
    assign eg_cycle = s_axis_tdata[28:17];
    assign cmd      = cmd_t'(s_axis_tuser);

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    always_comb
    begin
        push_data.vidx        = voice[VIDX_W-1:0];
        push_data.inc         = env_increment(rate, eg_cycle);
        push_data.decay_level = s_axis_tdata[15:11];
        push_data.hold_attack = s_axis_tdata[16];
        if (7'(voice) >= 7'(NUM_VOICES))
            push_data.kind = OP_BAD_VOICE;
        else
        begin
            case (cmd)
                CMD_STEP:    push_data.kind = OP_STEP;
                CMD_KEY_ON:  push_data.kind = OP_KEY_ON;
                CMD_KEY_OFF: push_data.kind = OP_KEY_OFF;
                default:     push_data.kind = OP_NOP;
            endcase
        end
    end

endmodule

/* rtl/core/eg_queue.sv */
// Short FIFO of classified items between the front end and the back end.
module eg_queue
    import eg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    output logic q_full,
    output logic q_valid,
    output op_t  q_data,
    input  logic pop
);

    op_t                entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign q_full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/core/eg_back.sv */
// Back end: per-voice state, the level update and the result register.
module eg_back
    import eg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  op_t                   q_data,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: level[9:0], env_phase[11:10], voice_active[12], zero fill[15:13]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [LEVEL_W-1:0]    level_reg  [NUM_VOICES];
    phase_t                phase_reg  [NUM_VOICES];
    logic                  active_reg [NUM_VOICES];

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [LEVEL_W-1:0]    cur_level;
    phase_t                cur_phase;
    logic                  cur_active;
    logic [LEVEL_W-1:0]    new_level;
    phase_t                new_phase;
    logic                  new_active;
    logic                  store_we;

    logic [14:0]           attack_prod;
    logic [10:0]           attack_dec;
    logic [10:0]           rise_sum;

    assign pop        = q_valid && (!out_valid_reg || m_axis_tready);
    assign cur_level  = level_reg[q_data.vidx];
    assign cur_phase  = phase_reg[q_data.vidx];
    assign cur_active = active_reg[q_data.vidx];

    // Attack falls by ceil((level + 1) * inc / 16); the others rise by inc.
    assign attack_prod = (15'(cur_level) + 15'd1) * 15'(q_data.inc);
    assign attack_dec  = 11'((attack_prod + 15'd15) >> 4);
    assign rise_sum    = 11'(cur_level) + 11'(q_data.inc);

    always_comb
    begin
        new_level  = cur_level;
        new_phase  = cur_phase;
        new_active = cur_active;
        store_we   = pop;
        case (q_data.kind)
            OP_KEY_ON:
            begin
                new_level  = LEVEL_MAX;
                new_phase  = PH_ATTACK;
                new_active = 1'b1;
            end
            OP_KEY_OFF:
            begin
                new_phase = PH_RELEASE;
            end
            OP_STEP:
            begin
                if (cur_active)
                begin
                    if (cur_phase == PH_ATTACK)
                    begin
                        if (cur_level == '0 && !q_data.hold_attack)
                            new_phase = PH_DECAY1;
                        else if (q_data.inc != '0 && cur_level != '0)
                            new_level = cur_level - attack_dec[LEVEL_W-1:0];
                    end
                    else
                    begin
                        if (cur_phase == PH_DECAY1 && cur_level[9:5] >= q_data.decay_level)
                            new_phase = PH_DECAY2;
                        if (rise_sum >= 11'(LEVEL_MAX))
                        begin
                            new_level  = LEVEL_MAX;
                            new_active = 1'b0;
                        end
                        else
                            new_level = rise_sum[LEVEL_W-1:0];
                    end
                end
            end
            OP_BAD_VOICE:
            begin
                new_level  = LEVEL_MAX;
                new_phase  = PH_RELEASE;
                new_active = 1'b0;
                store_we   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, new_active, new_phase, new_level};
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                level_reg[i]  <= LEVEL_MAX;
                phase_reg[i]  <= PH_RELEASE;
                active_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_we)
            begin
                level_reg[q_data.vidx]  <= new_level;
                phase_reg[q_data.vidx]  <= new_phase;
                active_reg[q_data.vidx] <= new_active;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/core/envelope_generator_step.sv */
// Top level of the 32-voice ADSR envelope generator.
//
//   Channel    Direction  Contents of one item
//   s_axis     in         tuser: cmd; tdata: voice, rate, decay_level, hold_attack, eg_cycle
//   m_axis     out        tdata: level, env_phase, voice_active
//
// The block takes one item per clock while the queue has room and gives one result per
// item. An accepted item is classified and written into the queue. When the back end
// pops it, the back end updates its voice and loads the result into the output register,
// which offers it on m_axis. The per-voice read-modify-write sits in the back end and
// completes at the pop, so items for the same voice may follow each other directly.
// Reset loads every voice with level 0x3FF, release and inactive at once; there is no
// clearing pass. A two-entry queue lets the input keep flowing while a result waits
// on m_axis_tready; s_axis_tready falls only when that queue is full.
`include "assert_macros.svh"

module envelope_generator_step
    import eg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: voice[4:0], rate[10:5], decay_level[15:11], hold_attack[16],
    //        eg_cycle[28:17], zero fill[31:29]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: level[9:0], env_phase[11:10], voice_active[12], zero fill[15:13]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Classified items travel from the front end through the queue to the back end.
    logic push;
    op_t  push_data;
    logic q_full;
    logic q_valid;
    op_t  q_data;
    logic pop;

    eg_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    eg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    eg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // An accepted item is in the queue at the next edge, since the queue never passes
    // an entry through in the cycle it is written.
    `EG_ASSERT_NEXT(a_push_lands, s_axis_tvalid && s_axis_tready, q_valid, "item lost in queue")

    // Every update the back end performs leaves a result in the output register.
    `EG_ASSERT_NEXT(a_pop_gives_result, pop, m_axis_tvalid, "update produced no result")

    // Only key on enters attack and it sets the voice active; attack never clears it.
    `EG_ASSERT_IMPLY(a_attack_active, m_axis_tvalid && (m_axis_tdata[11:10] == PH_ATTACK),
                     m_axis_tdata[12], "attack result for an inactive voice")

endmodule

/* bench/eg_bench_pkg.sv */
// Item types and the scoreboard that predicts and checks the envelope generator results.
package eg_bench_pkg;

    import eg_pkg::*;

    // Level increments for rates 2 to 47, one row for each value of rate bits 1..0.
    localparam int unsigned SLOW_STEPS [4][8] = '{
        '{0, 1, 0, 1, 0, 1, 0, 1},
        '{0, 1, 0, 1, 1, 1, 0, 1},
        '{0, 1, 1, 1, 0, 1, 1, 1},
        '{0, 1, 1, 1, 1, 1, 1, 1}
    };

    // Base increments for rates 48 to 59, doubled for every further group of four rates.
    localparam int unsigned FAST_STEPS [4][8] = '{
        '{1, 1, 1, 1, 1, 1, 1, 1},
        '{1, 1, 1, 2, 1, 1, 1, 2},
        '{1, 2, 1, 2, 1, 2, 1, 2},
        '{1, 2, 2, 2, 1, 2, 2, 2}
    };

    typedef struct {
        cmd_t               cmd;
        logic [VOICE_W-1:0] voice;
        logic [RATE_W-1:0]  rate;
        logic [DL_W-1:0]    decay_level;
        logic               hold_attack;
        logic [CYCLE_W-1:0] eg_cycle;
    } eg_item_t;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        phase_t             env_phase;
        logic               voice_active;
    } eg_result_t;

    class envelope_scoreboard;

        logic [LEVEL_W-1:0] level_of  [NUM_VOICES];
        phase_t             phase_of  [NUM_VOICES];
        bit                 active_of [NUM_VOICES];
        eg_result_t         awaited [$];

        // Every voice starts silent, in release and inactive.
        function new();
            for (int v = 0; v < NUM_VOICES; v++) begin
                level_of[v]  = LEVEL_MAX;
                phase_of[v]  = PH_RELEASE;
                active_of[v] = 1'b0;
            end
        endfunction

        // Level increment for one envelope step at the given rate and envelope cycle.
        function int unsigned step_increment(logic [RATE_W-1:0] rate,
                                             logic [CYCLE_W-1:0] cyc);
            int unsigned sh;
            int unsigned pick;
            sh = (rate < 44) ? 11 - (rate >> 2) : 0;
            if ((int'(cyc) & ((1 << sh) - 1)) != 0)
                return 0;
            pick = (int'(cyc) >> sh) & 7;
            if (rate < 2)
                return 0;
            if (rate < 48)
                return SLOW_STEPS[rate[1:0]][pick];
            if (rate < 60)
                return FAST_STEPS[rate[1:0]][pick] << ((rate - 48) >> 2);
            return 8;
        endfunction

        // Applies one item to the voice state and returns the result it must produce.
        function eg_result_t apply_item(eg_item_t it);
            eg_result_t  res;
            int unsigned lvl;
            int unsigned inc;
            phase_t      ph;
            if (int'(it.voice) >= NUM_VOICES) begin
                res.level        = LEVEL_MAX;
                res.env_phase    = PH_RELEASE;
                res.voice_active = 1'b0;
                return res;
            end
            lvl = level_of[it.voice];
            ph  = phase_of[it.voice];
            case (it.cmd)
                CMD_KEY_ON: begin
                    lvl = LEVEL_MAX;
                    ph  = PH_ATTACK;
                    active_of[it.voice] = 1'b1;
                end
                CMD_KEY_OFF: ph = PH_RELEASE;
                CMD_STEP: begin
                    if (active_of[it.voice]) begin
                        inc = step_increment(it.rate, it.eg_cycle);
                        if (ph == PH_ATTACK) begin
                            // Attack ends at zero unless held there.
                            if (lvl == 0 && !it.hold_attack)
                                ph = PH_DECAY1;
                            else if (inc > 0 && lvl > 0)
                                lvl = lvl - (((lvl + 1) * inc + 15) >> 4);
                        end else begin
                            if (ph == PH_DECAY1 && (lvl >> 5) >= it.decay_level)
                                ph = PH_DECAY2;
                            lvl = lvl + inc;
                            if (lvl >= LEVEL_MAX) begin
                                lvl = LEVEL_MAX;
                                active_of[it.voice] = 1'b0;
                            end
                        end
                    end
                end
                CMD_UNUSED: ;
                default: ;
            endcase
            level_of[it.voice] = lvl[LEVEL_W-1:0];
            phase_of[it.voice] = ph;
            res.level        = lvl[LEVEL_W-1:0];
            res.env_phase    = ph;
            res.voice_active = active_of[it.voice];
            return res;
        endfunction

        function void note_item(eg_item_t it);
            awaited.push_back(apply_item(it));
        endfunction

        // Returns 1 when the result matches the oldest awaited one; why names what differs.
        function bit check_result(eg_result_t got, output string why);
            eg_result_t want;
            why = "";
            if (awaited.size() == 0) begin
                why = $sformatf("unexpected result level %0d phase %0d active %0d",
                                got.level, got.env_phase, got.voice_active);
                return 1'b0;
            end
            want = awaited.pop_front();
            if (got.level !== want.level)
                why = {why, $sformatf(" level %0d want %0d", got.level, want.level)};
            if (got.env_phase !== want.env_phase)
                why = {why, $sformatf(" phase %0d want %0d", got.env_phase, want.env_phase)};
            if (got.voice_active !== want.voice_active)
                why = {why, $sformatf(" active %0d want %0d",
                                      got.voice_active, want.voice_active)};
            return why == "";
        endfunction

        function int pending();
            return awaited.size();
        endfunction

    endclass

endpackage

/* bench/tb_envelope_generator_step.sv */
// Self-checking bench for the envelope generator: directed and random items with stalls.
module tb_envelope_generator_step;

    import eg_pkg::*;
    import eg_bench_pkg::*;

    // Generous ceiling on the run; a correct run with the longest stalls stays well below.
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: voice[4:0], rate[10:5], decay_level[15:11], hold_attack[16],
    //        eg_cycle[28:17], zero fill[31:29]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: cmd[1:0]
    logic [CMD_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: level[9:0], env_phase[11:10], voice_active[12], zero fill[15:13]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    envelope_scoreboard board = new();
    int unsigned        mismatches   = 0;
    int unsigned        cycle_count  = 0;
    bit                 sender_burst = 1'b0;

    envelope_generator_step DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_envelope_generator_step NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d:%s", cycle_count, what);
    endtask

    // Idle length between items or ready windows: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Input monitor: every item taken by the block is decoded from the bus and predicted.
    always @(posedge clk)
    begin
        eg_item_t taken;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            taken.cmd         = cmd_t'(s_axis_tuser);
            taken.voice       = s_axis_tdata[4:0];
            taken.rate        = s_axis_tdata[10:5];
            taken.decay_level = s_axis_tdata[15:11];
            taken.hold_attack = s_axis_tdata[16];
            taken.eg_cycle    = s_axis_tdata[28:17];
            board.note_item(taken);
        end
    end

    // Output monitor: every result handed over is compared with the oldest prediction.
    always @(posedge clk)
    begin
        eg_result_t got;
        string      why;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.level        = m_axis_tdata[9:0];
            got.env_phase    = phase_t'(m_axis_tdata[11:10]);
            got.voice_active = m_axis_tdata[12];
            if (!board.check_result(got, why))
                report_mismatch(why);
        end
    end

    // Result side: ready windows of random length with random stalls between them. Some
    // windows are long, so the output also sees stretches with no back pressure at all.
    initial
    begin
        int unsigned open_len;
        int unsigned shut_len;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
            shut_len = pick_gap();
            m_axis_tready <= 1'b1;
            repeat (open_len) @(posedge clk);
            if (shut_len != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (shut_len) @(posedge clk);
            end
        end
    end

    // Offers one item after an optional idle gap and returns after an edge once it sees s_axis_tready high.
    // Valid stays high afterwards, so back-to-back items never drop it for a cycle.
    task automatic send_item(input cmd_t cmd, input logic [VOICE_W-1:0] voice,
                             input logic [RATE_W-1:0] rate, input logic [DL_W-1:0] dlevel,
                             input logic hold, input logic [CYCLE_W-1:0] cyc);
        int unsigned gap;
        gap = sender_burst ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cyc, hold, dlevel, rate, voice};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Holds the input idle until every predicted result has been handed over.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
    endtask

    // Walks one voice through a whole envelope by hand, plus the odd commands.
    task automatic run_directed();
        // A step on a voice that was never keyed on reports the reset state.
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b0, 12'h000);
        // The unused command code changes nothing.
        send_item(CMD_UNUSED, 5'd31, 6'd0, 5'd31, 1'b1, 12'hFFF);
        // Key off on an inactive voice only sets release.
        send_item(CMD_KEY_OFF, 5'd1, 6'd32, 5'd16, 1'b0, 12'h800);
        send_item(CMD_KEY_ON, 5'd0, 6'd0, 5'd0, 1'b0, 12'h000);
        // The two lowest rates never move the level.
        send_item(CMD_STEP, 5'd0, 6'd0, 5'd0, 1'b0, 12'h000);
        send_item(CMD_STEP, 5'd0, 6'd1, 5'd0, 1'b0, 12'h800);
        // Slowest moving rate, on the one cycle phase that lets it move.
        send_item(CMD_STEP, 5'd0, 6'd2, 5'd0, 1'b0, 12'h800);
        // Low cycle bits set mask the increment away.
        send_item(CMD_STEP, 5'd0, 6'd43, 5'd0, 1'b0, 12'h001);
        // Rate boundaries between the slow, the fast and the top rates.
        send_item(CMD_STEP, 5'd0, 6'd47, 5'd0, 1'b0, 12'hFFF);
        send_item(CMD_STEP, 5'd0, 6'd48, 5'd0, 1'b0, 12'h003);
        send_item(CMD_STEP, 5'd0, 6'd55, 5'd0, 1'b0, 12'h006);
        send_item(CMD_STEP, 5'd0, 6'd59, 5'd0, 1'b0, 12'h007);
        send_item(CMD_STEP, 5'd0, 6'd60, 5'd0, 1'b0, 12'h000);
        // Fastest attack, which halves the level each step until it reaches zero.
        for (int i = 0; i < 8; i++)
            send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b1, 12'h000);
        // A held attack stays at zero; released, it moves on to decay1.
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b1, 12'h000);
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b0, 12'h000);
        // Decay1 below the highest decay level, then past the lowest one into decay2.
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd31, 1'b0, 12'hFFF);
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b0, 12'hFFF);
        send_item(CMD_KEY_OFF, 5'd0, 6'd0, 5'd0, 1'b0, 12'h000);
        send_item(CMD_STEP, 5'd0, 6'd63, 5'd0, 1'b0, 12'hFFF);
        send_item(CMD_KEY_ON, 5'd31, 6'd63, 5'd31, 1'b1, 12'hFFF);
        send_item(CMD_STEP, 5'd31, 6'd63, 5'd31, 1'b1, 12'hFFF);
    endtask

    // Random part. A few hot voices are keyed on and then stepped mostly at fast rates
    // on cycle values that let the increment through, so envelopes run from attack all
    // the way to silence. Cold voices, key off, the unused code and masked cycles are
    // mixed in as noise. Every so often the sender runs without gaps or waits for the
    // block to drain completely.
    task automatic run_random(input int unsigned count);
        logic [VOICE_W-1:0] hot [3];
        logic [VOICE_W-1:0] v;
        logic [RATE_W-1:0]  rate;
        logic [CYCLE_W-1:0] cyc;
        int unsigned        roll;
        cmd_t               cmd;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
            begin
                sender_burst = ($urandom_range(0, 3) == 0);
                for (int h = 0; h < 3; h++)
                begin
                    hot[h] = VOICE_W'($urandom_range(0, 31));
                    send_item(CMD_KEY_ON, hot[h], RATE_W'($urandom_range(0, 63)),
                              DL_W'($urandom_range(0, 31)), 1'b0,
                              CYCLE_W'($urandom_range(0, 4095)));
                end
            end
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd = CMD_KEY_ON;
            else if (roll < 4)
                cmd = CMD_KEY_OFF;
            else if (roll < 5)
                cmd = CMD_UNUSED;
            else
                cmd = CMD_STEP;
            v = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 2)]
                                            : VOICE_W'($urandom_range(0, 31));
            rate = ($urandom_range(0, 9) < 7) ? RATE_W'($urandom_range(52, 63))
                                              : RATE_W'($urandom_range(0, 63));
            cyc = CYCLE_W'($urandom_range(0, 4095));
            if ($urandom_range(0, 1) == 1)
                cyc = cyc & (12'hFFF << $urandom_range(0, 11));
            send_item(cmd, v, rate, DL_W'($urandom_range(0, 31)),
                      ($urandom_range(0, 9) == 0), cyc);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_STEP;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        // Let every result of the directed part come out before the random part starts.
        wait_drained();
        run_random(RANDOM_ITEMS);
        wait_drained();
        // Any stray result that still arrives is caught before the final check.
        repeat (8) @(posedge clk);
        if (board.pending() != 0)
            report_mismatch($sformatf(" %0d results never arrived", board.pending()));

        if (mismatches == 0)
            $display("tb_envelope_generator_step OK");
        else
            $display("tb_envelope_generator_step NOT OK");
        $finish;
    end

endmodule
